/* sv/prld_pkg.sv */
package prld_pkg;

    // Field widths
    localparam int BYTE_BITS     = 8;
    localparam int NIBBLE_BITS   = 4;
    localparam int PATTERN_BYTES = 15;
    localparam int LOW_BYTES     = 8;
    localparam int HIGH_BYTES    = PATTERN_BYTES - LOW_BYTES;
    localparam int LOW_BITS      = LOW_BYTES * BYTE_BITS;
    localparam int HIGH_BITS     = HIGH_BYTES * BYTE_BITS;
    localparam int PICTURE_BITS  = 24;

    // Defaults and reset values
    localparam int COUNT_BITS_DEFAULT = 24;
    localparam logic [PICTURE_BITS-1:0] PICTURE_BYTES_RESET = 24'd115200;

    // Queue between parser and expander
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Configuration port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_IDX_BITS  = 1;
    localparam logic [REG_IDX_BITS-1:0] REG_PICTURE_BYTES = 1'b0;

    // One decoded run, ready for expansion
    typedef struct packed {
        logic [LOW_BITS-1:0]    low;
        logic [HIGH_BITS-1:0]   high;
        logic [NIBBLE_BITS-1:0] len;
        logic [NIBBLE_BITS-1:0] rep;
    } t_job;

    // Parser to queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // Queue to expander
    typedef struct packed {
        logic empty;
        t_job head;
    } t_head;

endpackage

/* sv/prld_front.sv */
module prld_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [prld_pkg::BYTE_BITS-1:0]      i_in_byte,
    output prld_pkg::t_push                     o_push
);

    logic                                 r_in_pattern, n_in_pattern;
    logic [prld_pkg::NIBBLE_BITS-1:0]     r_len, n_len;
    logic [prld_pkg::NIBBLE_BITS-1:0]     r_rep, n_rep;
    logic [prld_pkg::NIBBLE_BITS-1:0]     r_cnt, n_cnt;
    logic [prld_pkg::BYTE_BITS-1:0]       r_store [prld_pkg::PATTERN_BYTES];
    logic [prld_pkg::NIBBLE_BITS-1:0]     cnt_inc;
    logic                                 pattern_end;
    logic [prld_pkg::BYTE_BITS-1:0]       lane [prld_pkg::PATTERN_BYTES];

    assign cnt_inc     = r_cnt + 1'b1;
    assign pattern_end = r_in_pattern && (cnt_inc == r_len);

    // Parse header and pattern bytes
    always_comb begin
        n_in_pattern = r_in_pattern;
        n_len        = r_len;
        n_rep        = r_rep;
        n_cnt        = r_cnt;
        if (i_accept) begin
            if (!r_in_pattern) begin
                n_rep        = i_in_byte[prld_pkg::NIBBLE_BITS-1:0];
                n_len        = i_in_byte[prld_pkg::BYTE_BITS-1:prld_pkg::NIBBLE_BITS];
                n_cnt        = '0;
                n_in_pattern = (n_len != '0);
            end else if (pattern_end) begin
                n_in_pattern = 1'b0;
                n_cnt        = '0;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pattern <= 1'b0;
            r_len        <= '0;
            r_rep        <= '0;
            r_cnt        <= '0;
        end else begin
            r_in_pattern <= n_in_pattern;
            r_len        <= n_len;
            r_rep        <= n_rep;
            r_cnt        <= n_cnt;
        end
    end

    // Hold pattern bytes at their position
    always_ff @(posedge i_clk) begin
        if (i_accept && r_in_pattern &&
            (r_cnt != prld_pkg::NIBBLE_BITS'(prld_pkg::PATTERN_BYTES))) begin
            r_store[r_cnt] <= i_in_byte;
        end
    end

    // Build the run: current byte bypasses the store, unused lanes are zero
    always_comb begin
        for (int i = 0; i < prld_pkg::PATTERN_BYTES; i++) begin
            if (prld_pkg::NIBBLE_BITS'(i) >= r_len) begin
                lane[i] = '0;
            end else if (prld_pkg::NIBBLE_BITS'(i) == r_cnt) begin
                lane[i] = i_in_byte;
            end else begin
                lane[i] = r_store[i];
            end
        end
    end

    always_comb begin
        o_push.job.low  = '0;
        o_push.job.high = '0;
        for (int i = 0; i < prld_pkg::LOW_BYTES; i++) begin
            o_push.job.low[i*prld_pkg::BYTE_BITS +: prld_pkg::BYTE_BITS] = lane[i];
        end
        for (int i = 0; i < prld_pkg::HIGH_BYTES; i++) begin
            o_push.job.high[i*prld_pkg::BYTE_BITS +: prld_pkg::BYTE_BITS] =
                lane[i+prld_pkg::LOW_BYTES];
        end
        o_push.job.len = r_len;
        o_push.job.rep = r_rep;
        // Drop runs with zero repeat
        o_push.valid   = i_accept && pattern_end && (r_rep != '0);
    end

endmodule

/* sv/prld_fifo.sv */
module prld_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prld_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output prld_pkg::t_head o_head
);

    localparam int CNT_BITS = $clog2(prld_pkg::QUEUE_DEPTH + 1);

    prld_pkg::t_job                   r_mem [prld_pkg::QUEUE_DEPTH];
    logic [prld_pkg::QPTR_BITS-1:0]   r_wr, n_wr;
    logic [prld_pkg::QPTR_BITS-1:0]   r_rd, n_rd;
    logic [CNT_BITS-1:0]              r_cnt, n_cnt;
    logic                             do_wr;
    logic                             do_rd;

    assign o_full       = (r_cnt == CNT_BITS'(prld_pkg::QUEUE_DEPTH));
    assign o_head.empty = (r_cnt == '0);
    assign o_head.head  = r_mem[r_rd];
    assign do_wr        = i_push.valid && !o_full;
    assign do_rd        = i_pop && !o_head.empty;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wr = (r_wr == prld_pkg::QPTR_BITS'(prld_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_rd) begin
            n_rd = (r_rd == prld_pkg::QPTR_BITS'(prld_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

endmodule

/* sv/prld_back.sv */
module prld_back #(
    parameter int COUNT_BITS = prld_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  prld_pkg::t_head                   i_head,
    output logic                              o_fifo_pop,
    input  logic                              i_reload_now,
    input  logic [COUNT_BITS-1:0]             i_reload,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic [prld_pkg::LOW_BITS-1:0]     o_copy_low,
    output logic [prld_pkg::HIGH_BITS-1:0]    o_copy_high,
    output logic [prld_pkg::NIBBLE_BITS-1:0]  o_copy_bytes,
    output logic                              o_last_of_run,
    output logic                              o_picture_done
);

    logic                                 r_busy, n_busy;
    prld_pkg::t_job                       r_job;
    logic [prld_pkg::NIBBLE_BITS-1:0]     r_idx, n_idx;
    logic [COUNT_BITS-1:0]                r_rem, n_rem;
    logic                                 r_out_valid, n_out_valid;
    logic [prld_pkg::LOW_BITS-1:0]        r_low;
    logic [prld_pkg::HIGH_BITS-1:0]       r_high;
    logic [prld_pkg::NIBBLE_BITS-1:0]     r_bytes;
    logic                                 r_last;
    logic                                 r_done;
    logic                                 emit;
    logic                                 last_copy;
    logic                                 load;
    logic                                 done;
    logic [COUNT_BITS-1:0]                len_ext;

    assign emit       = r_busy && (!r_out_valid || i_pop);
    assign last_copy  = (r_idx == r_job.rep - 1'b1);
    assign load       = !i_head.empty && (!r_busy || (emit && last_copy));
    assign o_fifo_pop = load;
    assign len_ext    = COUNT_BITS'(r_job.len);
    assign done       = (len_ext >= r_rem);

    // Step through the copies of the current run
    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_idx = r_idx + 1'b1;
            if (last_copy) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
        // Count down the picture, reload on completion or on a picture size write
        if (i_reload_now) begin
            n_rem = i_reload;
        end else if (emit) begin
            n_rem = done ? i_reload : r_rem - len_ext;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_rem       <= COUNT_BITS'(prld_pkg::PICTURE_BYTES_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold run and output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head.head;
        end
        if (emit) begin
            r_low   <= r_job.low;
            r_high  <= r_job.high;
            r_bytes <= r_job.len;
            r_last  <= last_copy;
            r_done  <= done;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_copy_low     = r_low;
    assign o_copy_high    = r_high;
    assign o_copy_bytes   = r_bytes;
    assign o_last_of_run  = r_last;
    assign o_picture_done = r_done;

endmodule

/* sv/pattern_run_length_decoder_core.sv */
// A run's first copy reaches the result ports through the run queue, run register and output
// register. Throughput: one compressed byte per cycle while the run queue has room; the
// expander puts out one copy per cycle while its output is empty or popped, R copies per run.
// Reset (i_rst_n, synchronous, active low): parser expects a header, queue and output empty,
// picture size and remaining count return to 115200 bytes.
module pattern_run_length_decoder_core #(
    parameter int COUNT_BITS = prld_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Compressed byte input
    input  logic                                   push,
    output logic                                   full,
    input  logic [prld_pkg::BYTE_BITS-1:0]         i_in_byte,
    // Copy output
    output logic                                   empty,
    input  logic                                   pop,
    output logic [prld_pkg::LOW_BITS-1:0]          o_copy_low,
    output logic [prld_pkg::HIGH_BITS-1:0]         o_copy_high,
    output logic [prld_pkg::NIBBLE_BITS-1:0]       o_copy_bytes,
    output logic                                   o_last_of_run,
    output logic                                   o_picture_done,
    // Configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [prld_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [prld_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [prld_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    logic [prld_pkg::PICTURE_BITS-1:0]  r_picture_bytes;
    logic [prld_pkg::PICTURE_BITS-1:0]  reload_val;
    logic [prld_pkg::REG_IDX_BITS-1:0]  reg_idx;
    logic                               cfg_wr;
    logic                               pic_wr;
    logic                               accept;
    logic                               fifo_pop;
    prld_pkg::t_push                    push_job;
    prld_pkg::t_head                    head;

    // Register access
    assign pready  = 1'b1;
    assign reg_idx = paddr[prld_pkg::APB_ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pic_wr  = cfg_wr && (reg_idx == prld_pkg::REG_PICTURE_BYTES);
    assign prdata  = (reg_idx == prld_pkg::REG_PICTURE_BYTES) ?
                     prld_pkg::APB_DATA_BITS'(r_picture_bytes) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_picture_bytes <= prld_pkg::PICTURE_BYTES_RESET;
        end else if (pic_wr) begin
            r_picture_bytes <= pwdata[prld_pkg::PICTURE_BITS-1:0];
        end
    end

    // Reload the count from the size being written, else from the stored size
    assign reload_val = pic_wr ? pwdata[prld_pkg::PICTURE_BITS-1:0] : r_picture_bytes;

    assign accept = push && !full;

    prld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .o_push    (push_job)
    );

    prld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_job),
        .i_pop   (fifo_pop),
        .o_full  (full),
        .o_head  (head)
    );

    prld_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_fifo_pop     (fifo_pop),
        .i_reload_now   (pic_wr),
        .i_reload       (COUNT_BITS'(reload_val)),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_copy_low     (o_copy_low),
        .o_copy_high    (o_copy_high),
        .o_copy_bytes   (o_copy_bytes),
        .o_last_of_run  (o_last_of_run),
        .o_picture_done (o_picture_done)
    );

endmodule
